[rtl/core/wmj_pkg.sv]
// Shared types and constants of the wall miter joint unit.
`timescale 1ns / 1ps
package wmj_pkg;

  localparam int TW = 24;
  localparam int CK = 8;

  localparam logic CFG_LEFT = 1'b0;
  localparam logic CFG_RIGHT = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PARALLEL = 2'd1,
    ST_ZERO     = 2'd2
  } status_t;

endpackage

[rtl/core/wmj_delay.sv]
// Delay line of fixed depth that advances with the pipeline enable.
`timescale 1ns / 1ps
module wmj_delay #(
  parameter int W = 1,
  parameter int DEPTH = 1
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < DEPTH; i++) begin
        sr[i] <= '0;
      end
    end else if (en) begin
      sr[0] <= d;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign q = sr[DEPTH-1];

endmodule

[rtl/core/wmj_mul.sv]
// Pipelined unsigned multiplier that takes one slice of the second operand per stage.
`timescale 1ns / 1ps
module wmj_mul #(
  parameter int WA = 32,
  parameter int WB = 32,
  parameter int CK = 8
) (
  input  logic             clk,
  input  logic             en,
  input  logic [WA-1:0]    a,
  input  logic [WB-1:0]    b,
  output logic [WA+WB-1:0] p
);

  localparam int NS = (WB + CK - 1) / CK;
  localparam int WBP = NS * CK;
  localparam int WP = WA + WB;

  logic [WA-1:0]  a_q   [NS];
  logic [WBP-1:0] b_q   [NS];
  logic [WP-1:0]  acc_q [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic [WA-1:0]    a_in;
    logic [WBP-1:0]   b_in;
    logic [WP-1:0]    acc_in;
    logic [WA+CK-1:0] part;
    if (k == 0) begin : g_first
      assign a_in = a;
      assign b_in = WBP'(b);
      assign acc_in = '0;
    end else begin : g_next
      assign a_in = a_q[k-1];
      assign b_in = b_q[k-1];
      assign acc_in = acc_q[k-1];
    end
    assign part = a_in * b_in[k*CK +: CK];
    always_ff @(posedge clk) begin
      if (en) begin
        a_q[k] <= a_in;
        b_q[k] <= b_in;
        acc_q[k] <= acc_in + (WP'(part) << (k * CK));
      end
    end
  end

  assign p = acc_q[NS-1];

endmodule

[rtl/core/wmj_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module wmj_sqrt #(
  parameter int WX = 100
) (
  input  logic              clk,
  input  logic              en,
  input  logic [WX-1:0]     x,
  output logic [WX/2-1:0]   root
);

  localparam int WR = WX / 2;
  localparam int WM = WR + 3;

  logic [WX-1:0] x_q    [WR];
  logic [WM-1:0] rem_q  [WR];
  logic [WR-1:0] root_q [WR];

  for (genvar k = 0; k < WR; k++) begin : g_step
    logic [WX-1:0] x_in;
    logic [WM-1:0] rem_in;
    logic [WR-1:0] root_in;
    logic [WM-1:0] sh;
    logic [WM-1:0] trial;
    logic          ge;
    if (k == 0) begin : g_first
      assign x_in = x;
      assign rem_in = '0;
      assign root_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign rem_in = rem_q[k-1];
      assign root_in = root_q[k-1];
    end
    assign sh = {rem_in[WM-3:0], x_in[WX-1-2*k -: 2]};
    assign trial = {1'b0, root_in, 2'b01};
    assign ge = sh >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        x_q[k] <= x_in;
        rem_q[k] <= ge ? sh - trial : sh;
        root_q[k] <= {root_in[WR-2:0], ge};
      end
    end
  end

  assign root = root_q[WR-1];

endmodule

[rtl/core/wmj_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
module wmj_div #(
  parameter int WNUM = 110,
  parameter int WDD = 85,
  parameter int QW = 34
) (
  input  logic            clk,
  input  logic            en,
  input  logic [WNUM-1:0] num,
  input  logic [WDD-1:0]  dd,
  output logic [QW-1:0]   q
);

  logic [QW-1:0]  nl_q [QW];
  logic [WDD-1:0] d_q  [QW];
  logic [WDD-1:0] r_q  [QW];
  logic [QW-1:0]  q_q  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_step
    logic [QW-1:0]  nl_in;
    logic [WDD-1:0] d_in;
    logic [WDD-1:0] r_in;
    logic [QW-1:0]  q_in;
    logic [WDD:0]   rs;
    logic [WDD:0]   diff;
    logic           ge;
    logic [QW-1:0]  q_next;
    if (k == 0) begin : g_first
      assign nl_in = num[QW-1:0];
      assign d_in = dd;
      assign r_in = WDD'(num[WNUM-1:QW]);
      assign q_in = '0;
    end else begin : g_next
      assign nl_in = nl_q[k-1];
      assign d_in = d_q[k-1];
      assign r_in = r_q[k-1];
      assign q_in = q_q[k-1];
    end
    assign rs = {r_in, nl_in[QW-1-k]};
    assign diff = rs - {1'b0, d_in};
    assign ge = rs >= {1'b0, d_in};
    always_comb begin
      q_next = q_in;
      q_next[QW-1-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        nl_q[k] <= nl_in;
        d_q[k] <= d_in;
        r_q[k] <= ge ? diff[WDD-1:0] : rs[WDD-1:0];
        q_q[k] <= q_next;
      end
    end
  end

  assign q = q_q[QW-1];

endmodule

[rtl/core/wall_miter_joint_unit.sv]
// Top level of the wall miter joint unit: miter corner of two offset wall lines.
//
//   channel   direction  handshake             payload
//   in        input      in_valid / in_ready   joint, left end, right end (x, y)
//   out       output     out_valid / out_ready corner_x, corner_y, status
//   cfg       input      cfg_we                cfg_index, cfg_data
//
// One item enters per cycle unless a result waits at the output; the square root and
// divider stages resolve one bit per stage.
// Reset clears the valid bits and sets both thicknesses to 2.0.
// When a result waits at the output, the whole pipeline holds.
`timescale 1ns / 1ps
module wall_miter_joint_unit #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [wmj_pkg::TW-1:0]       cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [COORD_WIDTH-1:0] joint_x,
  input  logic signed [COORD_WIDTH-1:0] joint_y,
  input  logic signed [COORD_WIDTH-1:0] left_end_x,
  input  logic signed [COORD_WIDTH-1:0] left_end_y,
  input  logic signed [COORD_WIDTH-1:0] right_end_x,
  input  logic signed [COORD_WIDTH-1:0] right_end_y,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_WIDTH-1:0] corner_x,
  output logic signed [COORD_WIDTH-1:0] corner_y,
  output logic [1:0]                   status
);

  import wmj_pkg::*;

  localparam int CW = COORD_WIDTH;
  localparam int F = FRAC_BITS;
  localparam int LM = (CW + CK - 1) / CK;
  localparam int LT = (TW + CK - 1) / CK;
  localparam int WDS = 2 * CW + 2;
  localparam int WDM = 2 * CW + 1;
  localparam int WSS = 2 * CW + 1;
  localparam int WX = 2 * CW + 2 + 2 * F;
  localparam int WR = CW + 1 + F;
  localparam int WTL = WR + TW;
  localparam int WPN = WTL + CW;
  localparam int WNS = WPN + 2;
  localparam int WNM = WPN + 1;
  localparam int WDEN = WDM + F + 1;
  localparam int WNUM = ((WNM + 1 > WDEN) ? WNM + 1 : WDEN) + 1;
  localparam int WDD = WDM + F + 2;
  localparam int QW = CW + 2;
  localparam int WCMP = (WNUM > WDD + QW) ? WNUM : WDD + QW;
  localparam int TT = 3 + LM + WR + LT;
  localparam int TNA = TT + LM + 2;
  localparam int TQ = TNA + 1 + QW;
  localparam int LAT = TQ + 2;

  logic en;
  logic [TW-1:0] left_thickness;
  logic [TW-1:0] right_thickness;

  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      left_thickness <= TW'(131072);
      right_thickness <= TW'(131072);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEFT: left_thickness <= cfg_data;
        CFG_RIGHT: right_thickness <= cfg_data;
        default: ;
      endcase
    end
  end

  wmj_delay #(.W(1), .DEPTH(LAT)) u_valid (
    .clk(clk), .rst(rst), .en(en), .d(in_valid), .q(out_valid)
  );

  // Differences from the joint: left x, left y, right x, right y.
  logic signed [CW:0]   d1 [4];
  logic signed [CW-1:0] j1x, j1y;

  always_ff @(posedge clk) begin
    if (en) begin
      d1[0] <= (CW+1)'(left_end_x) - (CW+1)'(joint_x);
      d1[1] <= (CW+1)'(left_end_y) - (CW+1)'(joint_y);
      d1[2] <= (CW+1)'(right_end_x) - (CW+1)'(joint_x);
      d1[3] <= (CW+1)'(right_end_y) - (CW+1)'(joint_y);
      j1x <= joint_x;
      j1y <= joint_y;
    end
  end

  logic [CW-1:0]        m2 [4];
  logic [3:0]           n2;
  logic                 z2;
  logic signed [CW-1:0] j2x, j2y;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        m2[i] <= d1[i][CW] ? CW'(-d1[i]) : CW'(d1[i]);
        n2[i] <= d1[i][CW];
      end
      z2 <= (d1[0] == '0 && d1[1] == '0) || (d1[2] == '0 && d1[3] == '0);
      j2x <= j1x;
      j2y <= j1y;
    end
  end

  logic [2*CW-1:0] p1, p2, sq0, sq1, sq2, sq3;

  wmj_mul #(.WA(CW), .WB(CW), .CK(CK)) u_mul_p1 (
    .clk(clk), .en(en), .a(m2[0]), .b(m2[3]), .p(p1));
  wmj_mul #(.WA(CW), .WB(CW), .CK(CK)) u_mul_p2 (
    .clk(clk), .en(en), .a(m2[1]), .b(m2[2]), .p(p2));
  wmj_mul #(.WA(CW), .WB(CW), .CK(CK)) u_mul_sq0 (
    .clk(clk), .en(en), .a(m2[0]), .b(m2[0]), .p(sq0));
  wmj_mul #(.WA(CW), .WB(CW), .CK(CK)) u_mul_sq1 (
    .clk(clk), .en(en), .a(m2[1]), .b(m2[1]), .p(sq1));
  wmj_mul #(.WA(CW), .WB(CW), .CK(CK)) u_mul_sq2 (
    .clk(clk), .en(en), .a(m2[2]), .b(m2[2]), .p(sq2));
  wmj_mul #(.WA(CW), .WB(CW), .CK(CK)) u_mul_sq3 (
    .clk(clk), .en(en), .a(m2[3]), .b(m2[3]), .p(sq3));

  logic [3:0] ndet;

  wmj_delay #(.W(4), .DEPTH(LM)) u_dly_ndet (
    .clk(clk), .rst(rst), .en(en), .d(n2), .q(ndet));

  logic signed [WDS-1:0] t1, t2;
  logic signed [WDS-1:0] det3;
  logic [WSS-1:0]        ssl3, ssr3;

  assign t1 = signed'(WDS'(p1));
  assign t2 = signed'(WDS'(p2));

  always_ff @(posedge clk) begin
    if (en) begin
      det3 <= ((ndet[0] ^ ndet[3]) ? -t1 : t1) - ((ndet[1] ^ ndet[2]) ? -t2 : t2);
      ssl3 <= WSS'(sq0) + WSS'(sq1);
      ssr3 <= WSS'(sq2) + WSS'(sq3);
    end
  end

  logic [WDM-1:0] det_mag4;
  logic           det_neg4;
  logic           det_zero4;

  always_ff @(posedge clk) begin
    if (en) begin
      det_mag4 <= det3[WDS-1] ? WDM'(-det3) : WDM'(det3);
      det_neg4 <= det3[WDS-1];
      det_zero4 <= det3 == '0;
    end
  end

  logic [WR-1:0] root_l, root_r;

  wmj_sqrt #(.WX(WX)) u_sqrt_l (
    .clk(clk), .en(en), .x(WX'({ssl3, {(2*F){1'b0}}})), .root(root_l));
  wmj_sqrt #(.WX(WX)) u_sqrt_r (
    .clk(clk), .en(en), .x(WX'({ssr3, {(2*F){1'b0}}})), .root(root_r));

  logic [WTL-1:0] tl, tr;

  wmj_mul #(.WA(WR), .WB(TW), .CK(CK)) u_mul_tl (
    .clk(clk), .en(en), .a(root_l), .b(left_thickness), .p(tl));
  wmj_mul #(.WA(WR), .WB(TW), .CK(CK)) u_mul_tr (
    .clk(clk), .en(en), .a(root_r), .b(right_thickness), .p(tr));

  logic [4*CW-1:0] md;
  logic [3:0]      ns;

  wmj_delay #(.W(4*CW), .DEPTH(TT-2)) u_dly_mag (
    .clk(clk), .rst(rst), .en(en), .d({m2[3], m2[2], m2[1], m2[0]}), .q(md));
  wmj_delay #(.W(4), .DEPTH(TT+LM-2)) u_dly_nsgn (
    .clk(clk), .rst(rst), .en(en), .d(n2), .q(ns));

  logic [WPN-1:0] pxa, pxb, pya, pyb;

  wmj_mul #(.WA(WTL), .WB(CW), .CK(CK)) u_mul_pxa (
    .clk(clk), .en(en), .a(tl), .b(md[2*CW +: CW]), .p(pxa));
  wmj_mul #(.WA(WTL), .WB(CW), .CK(CK)) u_mul_pxb (
    .clk(clk), .en(en), .a(tr), .b(md[0 +: CW]), .p(pxb));
  wmj_mul #(.WA(WTL), .WB(CW), .CK(CK)) u_mul_pya (
    .clk(clk), .en(en), .a(tr), .b(md[CW +: CW]), .p(pya));
  wmj_mul #(.WA(WTL), .WB(CW), .CK(CK)) u_mul_pyb (
    .clk(clk), .en(en), .a(tl), .b(md[3*CW +: CW]), .p(pyb));

  logic signed [WNS-1:0] exa, exb, eya, eyb;
  logic signed [WNS-1:0] nx_s, ny_s;

  assign exa = signed'(WNS'(pxa));
  assign exb = signed'(WNS'(pxb));
  assign eya = signed'(WNS'(pya));
  assign eyb = signed'(WNS'(pyb));

  always_ff @(posedge clk) begin
    if (en) begin
      nx_s <= (ns[2] ? -exa : exa) + (ns[0] ? -exb : exb);
      ny_s <= (ns[1] ? -eya : eya) + (ns[3] ? -eyb : eyb);
    end
  end

  logic [WNM-1:0] nx_mag, ny_mag;
  logic           nx_neg, ny_neg;

  always_ff @(posedge clk) begin
    if (en) begin
      nx_mag <= nx_s[WNS-1] ? WNM'(-nx_s) : WNM'(nx_s);
      ny_mag <= ny_s[WNS-1] ? WNM'(-ny_s) : WNM'(ny_s);
      nx_neg <= nx_s[WNS-1];
      ny_neg <= ny_s[WNS-1];
    end
  end

  logic [WDM-1:0] dm_d;
  logic           dn_d;
  logic           dz_d;

  wmj_delay #(.W(WDM+2), .DEPTH(TNA-(4+LM))) u_dly_det (
    .clk(clk), .rst(rst), .en(en),
    .d({det_zero4, det_neg4, det_mag4}), .q({dz_d, dn_d, dm_d}));

  logic [WNUM-1:0] numx_c, numy_c, numx, numy;
  logic [WDD-1:0]  dd_c, ddx, ddy;
  logic [4:0]      flag_p;
  logic [4:0]      flag_q;

  assign numx_c = WNUM'({nx_mag, 1'b0}) + WNUM'({dm_d, {(F+1){1'b0}}});
  assign numy_c = WNUM'({ny_mag, 1'b0}) + WNUM'({dm_d, {(F+1){1'b0}}});
  assign dd_c = {dm_d, {(F+2){1'b0}}};

  always_ff @(posedge clk) begin
    if (en) begin
      numx <= numx_c;
      numy <= numy_c;
      ddx <= dd_c;
      ddy <= dd_c;
      flag_p <= {dz_d,
                 nx_neg == dn_d, WCMP'(numx_c) >= (WCMP'(dd_c) << QW),
                 ny_neg == dn_d, WCMP'(numy_c) >= (WCMP'(dd_c) << QW)};
    end
  end

  logic [QW-1:0] qx, qy;

  wmj_div #(.WNUM(WNUM), .WDD(WDD), .QW(QW)) u_div_x (
    .clk(clk), .en(en), .num(numx), .dd(ddx), .q(qx));
  wmj_div #(.WNUM(WNUM), .WDD(WDD), .QW(QW)) u_div_y (
    .clk(clk), .en(en), .num(numy), .dd(ddy), .q(qy));

  wmj_delay #(.W(5), .DEPTH(QW)) u_dly_flag (
    .clk(clk), .rst(rst), .en(en), .d(flag_p), .q(flag_q));

  logic signed [CW-1:0] jqx, jqy;
  logic                 zq;

  wmj_delay #(.W(2*CW+1), .DEPTH(TQ-2)) u_dly_side (
    .clk(clk), .rst(rst), .en(en), .d({j2x, j2y, z2}), .q({jqx, jqy, zq}));

  localparam logic [CW+1:0] CAP = {2'b01, {CW{1'b0}}};

  logic [CW+1:0]         magx, magy;
  logic signed [CW+2:0]  offx, offy;
  logic signed [CW+3:0]  sumx, sumy;
  logic signed [CW-1:0]  j5x, j5y;
  status_t               st5;

  assign magx = (flag_q[2] || qx > CAP) ? CAP : qx;
  assign magy = (flag_q[0] || qy > CAP) ? CAP : qy;
  assign offx = flag_q[3] ? -signed'((CW+3)'(magx)) : signed'((CW+3)'(magx));
  assign offy = flag_q[1] ? -signed'((CW+3)'(magy)) : signed'((CW+3)'(magy));

  always_ff @(posedge clk) begin
    if (en) begin
      sumx <= (CW+4)'(jqx) + (CW+4)'(offx);
      sumy <= (CW+4)'(jqy) + (CW+4)'(offy);
      j5x <= jqx;
      j5y <= jqy;
      st5 <= zq ? ST_ZERO : (flag_q[4] ? ST_PARALLEL : ST_OK);
    end
  end

  localparam logic signed [CW+3:0] HI_LIM = {5'b00000, {(CW-1){1'b1}}};
  localparam logic signed [CW+3:0] LO_LIM = {5'b11111, {(CW-1){1'b0}}};

  logic signed [CW-1:0] clx, cly;

  assign clx = (sumx > HI_LIM) ? CW'(HI_LIM) : ((sumx < LO_LIM) ? CW'(LO_LIM) : CW'(sumx));
  assign cly = (sumy > HI_LIM) ? CW'(HI_LIM) : ((sumy < LO_LIM) ? CW'(LO_LIM) : CW'(sumy));

  always_ff @(posedge clk) begin
    if (en) begin
      corner_x <= (st5 == ST_OK) ? clx : j5x;
      corner_y <= (st5 == ST_OK) ? cly : j5y;
      status <= st5;
    end
  end

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || status == ST_PARALLEL || status == ST_ZERO))
    else $error("status code out of range");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> out_valid)
    else $error("result lost while the pipeline was held");

  a_rise_after_advance: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_ready))
    else $error("output became valid without the pipeline advancing");

endmodule
